// ----- rtl/core/msst_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and record types for the minimum-spread spanning tree core.
// No dependencies; used by the core sequencer and the port checker.
package msst_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;

    localparam int VTX_W   = 11;                      // one-based vertex number
    localparam int VIDX_W  = $clog2(MAX_VERTICES);    // zero-based vertex index
    localparam int WGT_W   = 16;
    localparam int EIDX_W  = $clog2(MAX_EDGES);       // edge store address
    localparam int ECNT_W  = EIDX_W + 1;              // edge count incl. full
    localparam int RANK_W  = 4;
    localparam int BEST_W  = WGT_W + 1;

    localparam logic [BEST_W-1:0] BEST_NONE = '1;

    // one stored edge
    typedef struct packed {
        logic [VTX_W-1:0] from_v;
        logic [VTX_W-1:0] to_v;
        logic [WGT_W-1:0] weight;
    } edge_t;

    // one union-find entry
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [VIDX_W-1:0] parent;
    } uf_t;

    localparam int EDGE_W = $bits(edge_t);
    localparam int UF_W   = $bits(uf_t);

    // sequencer states, one-hot
    typedef enum logic [11:0] {
        S_LOAD     = 12'b0000_0000_0001,
        S_SORT_I   = 12'b0000_0000_0010,
        S_SORT_CUR = 12'b0000_0000_0100,
        S_SORT_CMP = 12'b0000_0000_1000,
        S_SORT_PUT = 12'b0000_0001_0000,
        S_INIT     = 12'b0000_0010_0000,
        S_EDGE     = 12'b0000_0100_0000,
        S_FIND_A   = 12'b0000_1000_0000,
        S_FIND_B   = 12'b0001_0000_0000,
        S_UNION    = 12'b0010_0000_0000,
        S_RANK     = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

endpackage

// ----- rtl/core/min_spread_spanning_tree_core.sv -----
`timescale 1ns / 1ps
// Minimum-spread spanning tree core: edge store, insertion sort, Kruskal passes.
// Depends on msst_pkg and msst_ram (edge store and union-find table).
//
// Edges are taken one per cycle while loading, into a 4096-entry edge store;
// edges beyond that are dropped. The edge marked last_edge starts the search
// and one result transaction follows: the least max-minus-min weight over
// spanning trees, or no_tree (at once, with fewer than two vertices). The
// search first insertion-sorts the store in place, then for each start edge
// runs one Kruskal pass: it initialises the union-find table, then per edge
// fetches it (all a skipped edge costs), walks from each endpoint to its
// root one node at a time, root included, and joins two differing roots by
// rank. No edge is taken while the search runs. A last edge is held off
// while a previous result is still waiting; configuration is always taken.
module min_spread_spanning_tree_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [msst_pkg::VTX_W-1:0] vertex_count,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [msst_pkg::VTX_W-1:0] from_vertex,
    input  logic [msst_pkg::VTX_W-1:0] to_vertex,
    input  logic [msst_pkg::WGT_W-1:0] weight,
    input  logic                       last_edge,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [msst_pkg::WGT_W-1:0] spread,
    output logic                       no_tree
);

    import msst_pkg::*;

    state_t              state_reg, state_next;
    logic [ECNT_W-1:0]   total_reg, total_next;
    logic [VTX_W-1:0]    vcount_reg;
    logic [VTX_W-1:0]    nv_reg, nv_next;
    logic [ECNT_W-1:0]   i_reg, i_next;
    logic [EIDX_W-1:0]   j_reg, j_next;
    edge_t               cur_reg, cur_next;
    logic [EIDX_W-1:0]   s_reg, s_next;
    logic [EIDX_W-1:0]   k_reg, k_next;
    logic [VIDX_W-1:0]   x_reg, x_next;
    logic [VIDX_W-1:0]   joined_reg, joined_next;
    logic [VIDX_W-1:0]   node_reg, node_next;
    logic [VIDX_W-1:0]   aidx_reg, aidx_next;
    logic [VIDX_W-1:0]   ra_reg, ra_next;
    logic [VIDX_W-1:0]   rb_reg, rb_next;
    logic [RANK_W-1:0]   rka_reg, rka_next;
    logic [RANK_W-1:0]   rkb_reg, rkb_next;
    logic [WGT_W-1:0]    w_reg, w_next;
    logic [WGT_W-1:0]    base_reg, base_next;
    logic [BEST_W-1:0]   best_reg, best_next;
    logic                out_valid_reg, out_valid_next;
    logic [WGT_W-1:0]    spread_reg, spread_next;
    logic                no_tree_reg, no_tree_next;

    logic                e_we;
    logic [EIDX_W-1:0]   e_waddr, e_raddr;
    edge_t               e_wdata, e_rdata;
    logic                u_we;
    logic [VIDX_W-1:0]   u_waddr, u_raddr;
    uf_t                 u_wdata, u_rdata;

    logic [VTX_W-1:0]    nv_cap;
    logic [VTX_W-1:0]    nv_dec;
    logic [VIDX_W-1:0]   nv_m1;
    logic [VTX_W-1:0]    from_dec, to_dec;
    logic                in_range;
    logic [VIDX_W-1:0]   joined_inc;
    logic [WGT_W-1:0]    sp;
    logic                k_last, s_last, adv;
    logic [EIDX_W-1:0]   k_inc;

    // edge store and union-find table
    msst_ram #(.W(EDGE_W), .D(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    msst_ram #(.W(UF_W), .D(MAX_VERTICES)) u_uf_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    // handshake outputs
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_LOAD) && (!out_valid_reg || !last_edge);
    assign out_valid = out_valid_reg;
    assign spread    = spread_reg;
    assign no_tree   = no_tree_reg;

    // helpers
    assign nv_cap     = (vcount_reg > VTX_W'(MAX_VERTICES)) ? VTX_W'(MAX_VERTICES)
                                                            : vcount_reg;
    assign nv_dec     = nv_reg - VTX_W'(1);
    assign nv_m1      = nv_dec[VIDX_W-1:0];
    assign from_dec   = e_rdata.from_v - VTX_W'(1);
    assign to_dec     = e_rdata.to_v - VTX_W'(1);
    assign in_range   = (e_rdata.from_v != '0) && (e_rdata.to_v != '0) &&
                        (e_rdata.from_v <= nv_reg) && (e_rdata.to_v <= nv_reg);
    assign joined_inc = joined_reg + VIDX_W'(1);
    assign sp         = w_reg - base_reg;
    assign k_inc      = k_reg + EIDX_W'(1);
    assign k_last     = ({1'b0, k_reg} + ECNT_W'(1)) >= total_reg;
    assign s_last     = ({1'b0, s_reg} + ECNT_W'(1)) >= total_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        nv_next        = nv_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        x_next         = x_reg;
        joined_next    = joined_reg;
        node_next      = node_reg;
        aidx_next      = aidx_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        rka_next       = rka_reg;
        rkb_next       = rkb_reg;
        w_next         = w_reg;
        base_next      = base_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !out_ready;
        spread_next    = spread_reg;
        no_tree_next   = no_tree_reg;
        e_we           = 1'b0;
        e_waddr        = j_reg;
        e_wdata        = cur_reg;
        e_raddr        = k_reg;
        u_we           = 1'b0;
        u_waddr        = x_reg;
        u_wdata        = '{rank: '0, parent: x_reg};
        u_raddr        = node_reg;
        adv            = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_valid && in_ready)
                begin
                    if (total_reg < ECNT_W'(MAX_EDGES))
                    begin
                        e_we       = 1'b1;
                        e_waddr    = total_reg[EIDX_W-1:0];
                        e_wdata    = '{from_v: from_vertex, to_v: to_vertex, weight: weight};
                        total_next = total_reg + ECNT_W'(1);
                    end
                    if (last_edge)
                    begin
                        nv_next = nv_cap;
                        if (nv_cap < VTX_W'(2))
                        begin
                            out_valid_next = 1'b1;
                            no_tree_next   = 1'b1;
                            spread_next    = '0;
                            total_next     = '0;
                        end
                        else
                        begin
                            i_next     = ECNT_W'(1);
                            state_next = S_SORT_I;
                        end
                    end
                end
            end
            // insertion sort: fetch next element
            S_SORT_I:
            begin
                e_raddr = i_reg[EIDX_W-1:0];
                if (i_reg >= total_reg)
                begin
                    s_next     = '0;
                    x_next     = '0;
                    state_next = S_INIT;
                end
                else
                begin
                    state_next = S_SORT_CUR;
                end
            end
            S_SORT_CUR:
            begin
                cur_next   = e_rdata;
                j_next     = i_reg[EIDX_W-1:0];
                e_raddr    = i_reg[EIDX_W-1:0] - EIDX_W'(1);
                state_next = S_SORT_CMP;
            end
            // shift heavier neighbours up one place
            S_SORT_CMP:
            begin
                e_we = 1'b1;
                if (e_rdata.weight > cur_reg.weight)
                begin
                    e_wdata = e_rdata;
                    j_next  = j_reg - EIDX_W'(1);
                    e_raddr = j_reg - EIDX_W'(2);
                    if (j_reg == EIDX_W'(1))
                    begin
                        state_next = S_SORT_PUT;
                    end
                end
                else
                begin
                    i_next     = i_reg + ECNT_W'(1);
                    state_next = S_SORT_I;
                end
            end
            S_SORT_PUT:
            begin
                e_we       = 1'b1;
                i_next     = i_reg + ECNT_W'(1);
                state_next = S_SORT_I;
            end
            // reset union-find entries for this pass
            S_INIT:
            begin
                u_we    = 1'b1;
                e_raddr = s_reg;
                if (x_reg == nv_m1)
                begin
                    k_next      = s_reg;
                    joined_next = '0;
                    state_next  = S_EDGE;
                end
                else
                begin
                    x_next = x_reg + VIDX_W'(1);
                end
            end
            S_EDGE:
            begin
                if (k_reg == s_reg)
                begin
                    base_next = e_rdata.weight;
                end
                if (in_range)
                begin
                    w_next     = e_rdata.weight;
                    aidx_next  = from_dec[VIDX_W-1:0];
                    node_next  = to_dec[VIDX_W-1:0];
                    u_raddr    = to_dec[VIDX_W-1:0];
                    state_next = S_FIND_A;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            // root walk from second endpoint
            S_FIND_A:
            begin
                if (u_rdata.parent == node_reg)
                begin
                    ra_next    = node_reg;
                    rka_next   = u_rdata.rank;
                    node_next  = aidx_reg;
                    u_raddr    = aidx_reg;
                    state_next = S_FIND_B;
                end
                else
                begin
                    node_next = u_rdata.parent;
                    u_raddr   = u_rdata.parent;
                end
            end
            // root walk from first endpoint
            S_FIND_B:
            begin
                if (u_rdata.parent == node_reg)
                begin
                    rb_next    = node_reg;
                    rkb_next   = u_rdata.rank;
                    state_next = S_UNION;
                end
                else
                begin
                    node_next = u_rdata.parent;
                    u_raddr   = u_rdata.parent;
                end
            end
            // union by rank and spanning check
            S_UNION:
            begin
                if (ra_reg == rb_reg)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    u_we        = 1'b1;
                    joined_next = joined_inc;
                    if (rka_reg < rkb_reg)
                    begin
                        u_waddr = ra_reg;
                        u_wdata = '{rank: rka_reg, parent: rb_reg};
                    end
                    else
                    begin
                        u_waddr = rb_reg;
                        u_wdata = '{rank: rkb_reg, parent: ra_reg};
                    end
                    if (joined_inc == nv_m1)
                    begin
                        if ({1'b0, sp} < best_reg)
                        begin
                            best_next = {1'b0, sp};
                        end
                        s_next = s_reg + EIDX_W'(1);
                        x_next = '0;
                        if (s_last)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_INIT;
                        end
                    end
                    else if (rka_reg == rkb_reg)
                    begin
                        state_next = S_RANK;
                    end
                    else
                    begin
                        adv = 1'b1;
                    end
                end
            end
            S_RANK:
            begin
                u_we    = 1'b1;
                u_waddr = ra_reg;
                u_wdata = '{rank: rka_reg + RANK_W'(1), parent: ra_reg};
                adv     = 1'b1;
            end
            // deliver the result and empty the store
            S_DONE:
            begin
                out_valid_next = 1'b1;
                if (best_reg == BEST_NONE)
                begin
                    no_tree_next = 1'b1;
                    spread_next  = '0;
                end
                else
                begin
                    no_tree_next = 1'b0;
                    spread_next  = best_reg[WGT_W-1:0];
                end
                best_next  = BEST_NONE;
                total_next = '0;
                state_next = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // step to the next edge of the pass; running out ends the search
        if (adv)
        begin
            if (k_last)
            begin
                state_next = S_DONE;
            end
            else
            begin
                k_next     = k_inc;
                e_raddr    = k_inc;
                state_next = S_EDGE;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            total_reg     <= '0;
            vcount_reg    <= VTX_W'(1);
            best_reg      <= BEST_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= vertex_count;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        nv_reg      <= nv_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        cur_reg     <= cur_next;
        s_reg       <= s_next;
        k_reg       <= k_next;
        x_reg       <= x_next;
        joined_reg  <= joined_next;
        node_reg    <= node_next;
        aidx_reg    <= aidx_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        rka_reg     <= rka_next;
        rkb_reg     <= rkb_next;
        w_reg       <= w_next;
        base_reg    <= base_next;
        spread_reg  <= spread_next;
        no_tree_reg <= no_tree_next;
    end

endmodule

// ----- rtl/core/msst_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port synchronous RAM, one write and one registered read.
// No dependencies.
module msst_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/msst_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the minimum-spread spanning tree core, bound to the top.
// Depends on msst_pkg widths and min_spread_spanning_tree_core ports.
module msst_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [msst_pkg::VTX_W-1:0] vertex_count,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [msst_pkg::VTX_W-1:0] from_vertex,
    input  logic [msst_pkg::VTX_W-1:0] to_vertex,
    input  logic [msst_pkg::WGT_W-1:0] weight,
    input  logic                       last_edge,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [msst_pkg::WGT_W-1:0] spread,
    input  logic                       no_tree
);

    // a waiting result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(spread) && $stable(no_tree))
        else $error("result changed while stalled");

    // no tree always reports zero spread
    a_no_tree_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_tree |-> spread == '0)
        else $error("no_tree with non-zero spread");

    // a closing edge is never taken over a pending result
    a_last_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_edge |-> !out_valid)
        else $error("last edge accepted while result pending");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration stalled");

endmodule

bind min_spread_spanning_tree_core msst_checker u_msst_checker (.*);
